/* hdl/diff_drive_odometry_top_macros.svh */
// Assertion macros shared by the odometry checker.
`ifndef DIFF_DRIVE_ODOMETRY_TOP_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_TOP_MACROS_SVH
// Clocked assertion, quiet while reset is high.
`define DDO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
// Antecedent in this cycle, consequent in the next.
`define DDO_ASSERT_NEXT(label, ante, cons, msg) \
  `DDO_ASSERT(label, (ante) |=> (cons), msg)
`endif

/* hdl/ddo_pkg.sv */
`timescale 1ns / 1ps
// Constants, types and helper functions for the odometry block.
package ddo_pkg;
  localparam int FRAC_BITS    = 16;
  localparam int TPM_W        = 16;
  localparam int TRACK_W      = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 24;
  localparam int CNT_W        = 32;
  localparam int TIME_W       = 24;
  localparam int QUAT_W       = 16;
  localparam int DIV_NW       = 64;
  localparam int DIV_DW       = 24;
  localparam int CORDIC_STEPS = 28;
  localparam int CSTEP_W      = 5;

  localparam logic [TPM_W-1:0]   TPM_RESET   = TPM_W'(4900);
  localparam logic [TRACK_W-1:0] TRACK_RESET =
    TRACK_W'((64'd72 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

  localparam logic signed [31:0] ANGLE_SCALE  = 32'sd683565276;
  localparam logic signed [31:0] USEC_PER_SEC = 32'sd1000000;
  localparam logic signed [31:0] CORDIC_GAIN  = 32'sd652032874;

  localparam logic [CFG_IDX_W-1:0] REG_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK = 2'd1;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE = 4'd0;
  localparam step_t S_DIST = 4'd1;
  localparam step_t S_DD   = 4'd2;
  localparam step_t S_MTH  = 4'd3;
  localparam step_t S_DTH  = 4'd4;
  localparam step_t S_RAD  = 4'd5;
  localparam step_t S_MLIN = 4'd6;
  localparam step_t S_LIN  = 4'd7;
  localparam step_t S_MANG = 4'd8;
  localparam step_t S_ANG  = 4'd9;
  localparam step_t S_CMID = 4'd10;
  localparam step_t S_MX   = 4'd11;
  localparam step_t S_MY   = 4'd12;
  localparam step_t S_AY   = 4'd13;
  localparam step_t S_CQ   = 4'd14;
  localparam step_t S_LOAD = 4'd15;

  typedef struct packed {
    step_t step;
    logic  accept;
    logic  start;
    logic  capture;
    logic  load_out;
  } ddo_cmd_t;

  typedef struct packed {
    logic time_zero;
    logic div_done;
    logic cordic_done;
  } ddo_status_t;

  function automatic logic signed [31:0] atan_entry(input logic [CSTEP_W-1:0] i);
    logic signed [31:0] r;
    unique case (i)
      5'd0:  r = 32'sd536870912;
      5'd1:  r = 32'sd316933406;
      5'd2:  r = 32'sd167458907;
      5'd3:  r = 32'sd85004756;
      5'd4:  r = 32'sd42667331;
      5'd5:  r = 32'sd21354465;
      5'd6:  r = 32'sd10679838;
      5'd7:  r = 32'sd5340245;
      5'd8:  r = 32'sd2670163;
      5'd9:  r = 32'sd1335087;
      5'd10: r = 32'sd667544;
      5'd11: r = 32'sd333772;
      5'd12: r = 32'sd166886;
      5'd13: r = 32'sd83443;
      5'd14: r = 32'sd41722;
      5'd15: r = 32'sd20861;
      5'd16: r = 32'sd10430;
      5'd17: r = 32'sd5215;
      5'd18: r = 32'sd2608;
      5'd19: r = 32'sd1304;
      5'd20: r = 32'sd652;
      5'd21: r = 32'sd326;
      5'd22: r = 32'sd163;
      5'd23: r = 32'sd81;
      5'd24: r = 32'sd41;
      5'd25: r = 32'sd20;
      5'd26: r = 32'sd10;
      5'd27: r = 32'sd5;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    priority if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

/* hdl/ddo_div.sv */
`timescale 1ns / 1ps
// Bit-serial signed divider rounding half away from zero.
module ddo_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [ddo_pkg::DIV_NW-1:0]   numer,
  input  logic        [ddo_pkg::DIV_DW-1:0]   denom,
  output logic                                done,
  output logic signed [ddo_pkg::DIV_NW-1:0]   quot
);
  import ddo_pkg::*;
  localparam int CW = $clog2(DIV_NW + 1);

  logic              busy;
  logic [CW-1:0]     count;
  logic              neg;
  logic [DIV_NW-1:0] dvd;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dsr;
  logic [DIV_NW-1:0] mag;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW+1:0] diff;

  always_comb begin
    mag   = numer[DIV_NW-1] ? DIV_NW'(-numer) : DIV_NW'(numer);
    trial = {rem, dvd[DIV_NW-1]};
    diff  = {1'b0, trial} - {2'b00, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CW'(DIV_NW);
    end else if (busy && count != '0) begin
      count <= count - 1'b1;
    end else if (busy) begin
      busy <= 1'b0;
    end
  end

  // Bias the magnitude by half the divisor, then restore one bit a cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= numer[DIV_NW-1];
      dvd <= mag + (DIV_NW'(denom) >> 1);
      rem <= '0;
      dsr <= denom;
    end else if (busy && count != '0) begin
      if (!diff[DIV_DW+1]) begin
        rem <= diff[DIV_DW-1:0];
        dvd <= {dvd[DIV_NW-2:0], 1'b1};
      end else begin
        rem <= trial[DIV_DW-1:0];
        dvd <= {dvd[DIV_NW-2:0], 1'b0};
      end
    end
  end

  assign done = busy && (count == '0);
  assign quot = neg ? -$signed(dvd) : $signed(dvd);
endmodule

/* hdl/ddo_cordic.sv */
`timescale 1ns / 1ps
// Iterative CORDIC giving cosine and sine of a binary angle in Q.30.
module ddo_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import ddo_pkg::*;

  logic               busy;
  logic [CSTEP_W-1:0] idx;
  logic [1:0]         quad;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
  logic signed [31:0] xs;
  logic signed [31:0] ys;

  assign xs = x >>> idx;
  assign ys = y >>> idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && idx != CSTEP_W'(CORDIC_STEPS)) begin
      idx <= idx + 1'b1;
    end else if (busy) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quad <= angle[31:30];
      z    <= $signed({2'b00, angle[29:0]});
      x    <= CORDIC_GAIN;
      y    <= '0;
    end else if (busy && idx != CSTEP_W'(CORDIC_STEPS)) begin
      if (!z[31]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_entry(idx);
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_entry(idx);
      end
    end
  end

  // Rotate the first-quadrant result into the angle's quadrant.
  always_comb begin
    unique case (quad)
      2'd0: begin cos_o = x;  sin_o = y;  end
      2'd1: begin cos_o = -y; sin_o = x;  end
      2'd2: begin cos_o = -x; sin_o = -y; end
      default: begin cos_o = y; sin_o = -x; end
    endcase
  end

  assign done = busy && (idx == CSTEP_W'(CORDIC_STEPS));
endmodule

/* hdl/ddo_datapath.sv */
`timescale 1ns / 1ps
// Odometry datapath: state, configuration, multiplier, divider and CORDIC.
module ddo_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ddo_pkg::ddo_cmd_t                     cmd,
  output ddo_pkg::ddo_status_t                  status,
  input  logic                                  cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [ddo_pkg::CNT_W-1:0]      right_front_count,
  input  logic signed [ddo_pkg::CNT_W-1:0]      left_front_count,
  input  logic signed [ddo_pkg::CNT_W-1:0]      right_rear_count,
  input  logic signed [ddo_pkg::CNT_W-1:0]      left_rear_count,
  input  logic [ddo_pkg::TIME_W-1:0]            elapsed_time,
  output logic signed [31:0]                    pos_x,
  output logic signed [31:0]                    pos_y,
  output logic [31:0]                           heading,
  output logic signed [ddo_pkg::QUAT_W-1:0]     quat_z,
  output logic signed [ddo_pkg::QUAT_W-1:0]     quat_w,
  output logic signed [31:0]                    linear_speed,
  output logic signed [31:0]                    turn_rate
);
  import ddo_pkg::*;

  function automatic logic signed [QUAT_W-1:0] to_q15(input logic signed [31:0] v);
    logic signed [32:0]       r;
    logic signed [QUAT_W-1:0] q;
    r = ($signed({v[31], v}) + 33'sd16384) >>> 15;
    priority if (r > 33'sd32767) q = 16'sh7FFF;
    else if (r < -33'sd32768) q = 16'sh8000;
    else q = r[QUAT_W-1:0];
    return q;
  endfunction

  logic [TPM_W-1:0]   tpm;
  logic [TRACK_W-1:0] trk;
  logic [CNT_W-1:0]   prev0, prev1, prev2, prev3;
  logic [31:0]        posx, posy, head;

  logic [TIME_W-1:0]  dt_r;
  logic signed [33:0] sum_r, dif_r;
  logic signed [31:0] travel, dd, rad, lin, ang, cx, cy;
  logic [32:0]        dth;
  logic signed [63:0] prod;
  logic signed [QUAT_W-1:0] qz, qw;

  logic [CNT_W-1:0]   d0, d1, d2, d3;
  logic signed [32:0] sr, sl;
  logic [TPM_W-1:0]   tpm_eff;
  logic [TRACK_W-1:0] trk_eff;

  logic signed [DIV_NW-1:0] div_n;
  logic [DIV_DW-1:0]        div_d;
  logic                     div_done;
  logic signed [DIV_NW-1:0] div_q;

  logic [31:0]        c_angle;
  logic               c_done;
  logic signed [31:0] c_cos, c_sin;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] rnd;
  logic [31:0]        pos_inc;

  always_comb begin
    d0 = right_front_count - prev0;
    d1 = left_front_count - prev1;
    d2 = right_rear_count - prev2;
    d3 = left_rear_count - prev3;
    sr = $signed({d0[31], d0}) + $signed({d2[31], d2});
    sl = $signed({d1[31], d1}) + $signed({d3[31], d3});
    tpm_eff = (tpm == '0) ? TPM_W'(1) : tpm;
    trk_eff = (trk == '0) ? TRACK_W'(1) : trk;
    rnd     = prod + 64'sd536870912;
    pos_inc = rnd[61:30];
  end

  always_comb begin
    unique case (cmd.step)
      S_DIST: begin
        div_n = DIV_NW'(sum_r) <<< FRAC_BITS;
        div_d = DIV_DW'({tpm_eff, 2'b00});
      end
      S_DD: begin
        div_n = DIV_NW'(dif_r) <<< FRAC_BITS;
        div_d = DIV_DW'({tpm_eff, 1'b0});
      end
      S_RAD: begin
        div_n = DIV_NW'(dd) <<< FRAC_BITS;
        div_d = DIV_DW'(trk_eff);
      end
      S_LIN, S_ANG: begin
        div_n = prod;
        div_d = DIV_DW'(dt_r);
      end
      default: begin
        div_n = prod;
        div_d = DIV_DW'(trk_eff);
      end
    endcase
  end

  always_comb begin
    unique case (cmd.step)
      S_MTH:  begin mul_a = dd;     mul_b = ANGLE_SCALE;  end
      S_MANG: begin mul_a = rad;    mul_b = USEC_PER_SEC; end
      S_MX:   begin mul_a = travel; mul_b = cx;           end
      S_MY:   begin mul_a = travel; mul_b = cy;           end
      default: begin mul_a = travel; mul_b = USEC_PER_SEC; end
    endcase
  end

  // Midpoint heading for the pose step, half heading for the quaternion.
  assign c_angle = (cmd.step == S_CMID) ? head + dth[32:1] : {1'b0, head[31:1]};

  ddo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start && cmd.step != S_CMID && cmd.step != S_CQ),
    .numer (div_n),
    .denom (div_d),
    .done  (div_done),
    .quot  (div_q)
  );

  ddo_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start && (cmd.step == S_CMID || cmd.step == S_CQ)),
    .angle (c_angle),
    .done  (c_done),
    .cos_o (c_cos),
    .sin_o (c_sin)
  );

  assign status.time_zero   = (elapsed_time == '0);
  assign status.div_done    = div_done;
  assign status.cordic_done = c_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      tpm <= TPM_RESET;
      trk <= TRACK_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_TICKS) tpm <= cfg_data[TPM_W-1:0];
      if (cfg_index == REG_TRACK) trk <= cfg_data[TRACK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev0 <= '0;
      prev1 <= '0;
      prev2 <= '0;
      prev3 <= '0;
      posx  <= '0;
      posy  <= '0;
      head  <= '0;
    end else begin
      if (cmd.accept) begin
        prev0 <= right_front_count;
        prev1 <= left_front_count;
        prev2 <= right_rear_count;
        prev3 <= left_rear_count;
      end
      if (cmd.step == S_MY) posx <= posx + pos_inc;
      if (cmd.step == S_AY) begin
        posy <= posy + pos_inc;
        head <= head + dth[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dt_r  <= elapsed_time;
      sum_r <= $signed({sr[32], sr}) + $signed({sl[32], sl});
      dif_r <= $signed({sr[32], sr}) - $signed({sl[32], sl});
    end
    if (cmd.step == S_MTH || cmd.step == S_MLIN || cmd.step == S_MANG ||
        cmd.step == S_MX || cmd.step == S_MY) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
    if (cmd.capture) begin
      unique case (cmd.step)
        S_DIST: travel <= sat32(div_q);
        S_DD:   dd     <= sat32(div_q);
        S_DTH:  dth    <= div_q[32:0];
        S_RAD:  rad    <= sat32(div_q);
        S_LIN:  lin    <= sat32(div_q);
        S_ANG:  ang    <= sat32(div_q);
        S_CMID: begin
          cx <= c_cos;
          cy <= c_sin;
        end
        S_CQ: begin
          qz <= to_q15(c_sin);
          qw <= to_q15(c_cos);
        end
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      pos_x        <= posx;
      pos_y        <= posy;
      heading      <= head;
      quat_z       <= qz;
      quat_w       <= qw;
      linear_speed <= lin;
      turn_rate    <= ang;
    end
  end
endmodule

/* hdl/ddo_ctrl.sv */
`timescale 1ns / 1ps
// Odometry sequencer: steps the datapath through one item and owns the handshakes.
module ddo_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ddo_pkg::ddo_status_t status,
  output ddo_pkg::ddo_cmd_t    cmd
);
  import ddo_pkg::*;

  function automatic step_t succ(input step_t s);
    step_t r;
    unique case (s)
      S_IDLE: r = S_DIST;
      S_DIST: r = S_DD;
      S_DD:   r = S_MTH;
      S_MTH:  r = S_DTH;
      S_DTH:  r = S_RAD;
      S_RAD:  r = S_MLIN;
      S_MLIN: r = S_LIN;
      S_LIN:  r = S_MANG;
      S_MANG: r = S_ANG;
      S_ANG:  r = S_CMID;
      S_CMID: r = S_MX;
      S_MX:   r = S_MY;
      S_MY:   r = S_AY;
      S_AY:   r = S_CQ;
      S_CQ:   r = S_LOAD;
      S_LOAD: r = S_IDLE;
    endcase
    return r;
  endfunction

  step_t state, state_next;
  logic  busy, busy_next;

  always_comb begin
    state_next   = state;
    busy_next    = busy;
    cmd.step     = state;
    cmd.accept   = 1'b0;
    cmd.start    = 1'b0;
    cmd.capture  = 1'b0;
    cmd.load_out = 1'b0;
    in_ready     = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        // Drop an item with zero elapsed time.
        if (in_valid && !status.time_zero) begin
          cmd.accept = 1'b1;
          state_next = S_DIST;
        end
      end
      S_DIST, S_DD, S_DTH, S_RAD, S_LIN, S_ANG: begin
        if (!busy) begin
          cmd.start = 1'b1;
          busy_next = 1'b1;
        end else if (status.div_done) begin
          cmd.capture = 1'b1;
          busy_next   = 1'b0;
          state_next  = succ(state);
        end
      end
      S_CMID, S_CQ: begin
        if (!busy) begin
          cmd.start = 1'b1;
          busy_next = 1'b1;
        end else if (status.cordic_done) begin
          cmd.capture = 1'b1;
          busy_next   = 1'b0;
          state_next  = succ(state);
        end
      end
      S_MTH, S_MLIN, S_MANG, S_MX, S_MY, S_AY: begin
        state_next = succ(state);
      end
      S_LOAD: begin
        // Hold until the output register is free.
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= busy_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

/* hdl/diff_drive_odometry_top.sv */
`timescale 1ns / 1ps
// From item acceptance to out_valid the block runs six divisions, two CORDIC runs, six
// multiply and update steps and the output load, which waits until the output register is free.
// A single shared divider and CORDIC serve each item, so a new item is taken only once the last is loaded.
// The result sits in an output register, so the next item is taken while it waits.
// An item with zero elapsed time is taken and dropped without starting work.
// Reset (synchronous, active high) clears pose, stored counts and loads register defaults.
module diff_drive_odometry_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ddo_pkg::CNT_W-1:0]      right_front_count,
  input  logic signed [ddo_pkg::CNT_W-1:0]      left_front_count,
  input  logic signed [ddo_pkg::CNT_W-1:0]      right_rear_count,
  input  logic signed [ddo_pkg::CNT_W-1:0]      left_rear_count,
  input  logic [ddo_pkg::TIME_W-1:0]            elapsed_time,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [31:0]                    pos_x,
  output logic signed [31:0]                    pos_y,
  output logic [31:0]                           heading,
  output logic signed [ddo_pkg::QUAT_W-1:0]     quat_z,
  output logic signed [ddo_pkg::QUAT_W-1:0]     quat_w,
  output logic signed [31:0]                    linear_speed,
  output logic signed [31:0]                    turn_rate
);
  import ddo_pkg::*;

  ddo_cmd_t    cmd;
  ddo_status_t status;

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ddo_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .right_front_count (right_front_count),
    .left_front_count  (left_front_count),
    .right_rear_count  (right_rear_count),
    .left_rear_count   (left_rear_count),
    .elapsed_time      (elapsed_time),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .heading           (heading),
    .quat_z            (quat_z),
    .quat_w            (quat_w),
    .linear_speed      (linear_speed),
    .turn_rate         (turn_rate)
  );
endmodule

/* hdl/ddo_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the odometry block and their binding.
`include "diff_drive_odometry_top_macros.svh"
module ddo_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [ddo_pkg::TIME_W-1:0]        elapsed_time,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [31:0]                pos_x,
  input logic [31:0]                       heading
);
  `DDO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pos_x) && $stable(heading), "stalled result changed")
  `DDO_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready && elapsed_time != '0, !in_ready, "block idle right after taking an item")
  `DDO_ASSERT_NEXT(a_drop_stays_idle, in_valid && in_ready && elapsed_time == '0, in_ready, "zero-time item started work")
  `DDO_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(!in_ready), "result appeared without work")
endmodule

bind diff_drive_odometry_top ddo_checker u_ddo_checker (.*);

/* bench/diff_drive_odometry_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the differential-drive odometry block.
module diff_drive_odometry_top_tb;
  import ddo_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 600;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int NUM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 220;

  typedef struct packed {
    logic signed [31:0] c0, c1, c2, c3;
    logic [TIME_W-1:0]  dt;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] px, py;
    logic [31:0]        hd;
    logic signed [15:0] qz, qw;
    logic signed [31:0] lin, ang;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] right_front_count = '0, left_front_count = '0;
  logic signed [31:0] right_rear_count = '0, left_rear_count = '0;
  logic [TIME_W-1:0] elapsed_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] pos_x, pos_y, linear_speed, turn_rate;
  logic [31:0] heading;
  logic signed [15:0] quat_z, quat_w;

  diff_drive_odometry_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sample_t pending_samples[$];
  pose_t   expected_poses[$];
  int      mismatches = 0;
  int      items_sent = 0;
  int      poses_checked = 0;
  bit      no_idle = 1'b0;
  longint  cycle_count = 0;

  // Model-side copies of registers and state
  logic [15:0] m_tpm;
  logic [23:0] m_track;
  logic [31:0] m_prev[4];
  logic [31:0] m_x, m_y, m_hd;
  // Generator-side view of the last counts the block kept
  logic [31:0] gen_prev[4];

  function automatic longint round_div(longint n, longint d);
    longint unsigned m, q;
    m = (n < 0) ? longint'(0) - n : n;
    q = (m + longint'(d) / 2) / longint'(d);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint t[28] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
    return t[i];
  endfunction

  task automatic rotate(input logic [31:0] a, output longint co, output longint si);
    longint x, y, z, xs, ys;
    x = 652032874;
    y = 0;
    z = longint'(a[29:0]);
    for (int i = 0; i < 28; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_step(i);
      end else begin
        x = x + ys; y = y - xs; z = z + atan_step(i);
      end
    end
    case (a[31:30])
      2'd0: begin co = x;  si = y;  end
      2'd1: begin co = -y; si = x;  end
      2'd2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endtask

  function automatic logic signed [15:0] to_half(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic advance_pose(input sample_t s);
    longint d[4], sr, sl, t, w, travel, dd, dth, rad, c, sn;
    logic [31:0] cur[4];
    logic [63:0] dth_u;
    logic [31:0] mid;
    longint px_step, py_step;
    pose_t p;
    if (s.dt == 0) return;
    cur[0] = s.c0; cur[1] = s.c1; cur[2] = s.c2; cur[3] = s.c3;
    for (int i = 0; i < 4; i++) begin
      d[i] = longint'(signed'(cur[i] - m_prev[i]));
      m_prev[i] = cur[i];
    end
    t = (m_tpm == 0) ? 1 : longint'(m_tpm);
    w = (m_track == 0) ? 1 : longint'(m_track);
    sr = d[0] + d[2];
    sl = d[1] + d[3];
    travel = clamp32(round_div((sr + sl) <<< FRAC_BITS, 4 * t));
    dd = clamp32(round_div((sr - sl) <<< FRAC_BITS, 2 * t));
    dth = round_div(dd * 683565276, w);
    dth_u = dth;
    mid = m_hd + dth_u[32:1];
    rotate(mid, c, sn);
    px_step = (travel * c + (64'sd1 <<< 29)) >>> 30;
    py_step = (travel * sn + (64'sd1 <<< 29)) >>> 30;
    m_x = m_x + px_step[31:0];
    m_y = m_y + py_step[31:0];
    m_hd = m_hd + dth_u[31:0];
    rad = clamp32(round_div(dd <<< FRAC_BITS, w));
    p.px = m_x;
    p.py = m_y;
    p.hd = m_hd;
    rotate(m_hd >> 1, c, sn);
    p.qz = to_half(sn);
    p.qw = to_half(c);
    p.lin = clamp32(round_div(travel * 1000000, longint'(s.dt)));
    p.ang = clamp32(round_div(rad * 1000000, longint'(s.dt)));
    expected_poses.push_back(p);
  endtask

  // Queue one sample; random-walk counts with occasional jumps and noise
  task automatic queue_sample(input int span, input logic [TIME_W-1:0] dt_in,
                              input bit wild);
    sample_t s;
    logic [31:0] c[4];
    for (int i = 0; i < 4; i++) begin
      if (wild) c[i] = $urandom;
      else c[i] = gen_prev[i] + 32'($signed($urandom_range(2 * span, 0)) - span);
    end
    s = '{c[0], c[1], c[2], c[3], dt_in};
    if (dt_in != 0) for (int i = 0; i < 4; i++) gen_prev[i] = c[i];
    pending_samples.push_back(s);
  endtask

  task automatic queue_exact(input logic [31:0] a, b, e, f, input logic [TIME_W-1:0] dt_in);
    pending_samples.push_back('{a, b, e, f, dt_in});
    if (dt_in != 0) begin
      gen_prev[0] = a; gen_prev[1] = b; gen_prev[2] = e; gen_prev[3] = f;
    end
  endtask

  function automatic logic [TIME_W-1:0] pick_dt();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return 24'd1;
    if (r < 14) return 24'hFFFFFF;
    if (r < 22) return TIME_W'($urandom);
    return TIME_W'($urandom_range(50000, 200));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx == REG_TICKS) m_tpm = v[15:0];
    else if (idx == REG_TRACK) m_track = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || expected_poses.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: hold each item until taken, then draw a gap
  int send_wait = 0;
  always @(posedge clk) begin
    sample_t s;
    int gap;
    if (rst) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else if (in_valid && in_ready) begin
      gap = no_idle ? 0 : $urandom_range(7);
      if (gap == 0 && pending_samples.size() != 0) begin
        s = pending_samples.pop_front();
        {right_front_count, left_front_count, right_rear_count, left_rear_count,
         elapsed_time} <= s;
      end else begin
        in_valid <= 1'b0;
        send_wait <= (gap > 0) ? gap - 1 : 0;
      end
    end else if (!in_valid) begin
      if (send_wait > 0) send_wait <= send_wait - 1;
      else if (pending_samples.size() != 0) begin
        s = pending_samples.pop_front();
        {right_front_count, left_front_count, right_rear_count, left_rear_count,
         elapsed_time} <= s;
        in_valid <= 1'b1;
      end
    end
  end

  // Predict on every accepted item
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      items_sent++;
      advance_pose({right_front_count, left_front_count, right_rear_count,
                    left_rear_count, elapsed_time});
    end
  end

  // Monitor: random backpressure and compare against oldest expected pose
  int recv_wait = 0;
  always @(posedge clk) begin
    pose_t got, want;
    int nw;
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{pos_x, pos_y, heading, quat_z, quat_w, linear_speed, turn_rate};
        poses_checked++;
        if (expected_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result: %p", got);
        end else begin
          want = expected_poses.pop_front();
          if (got.px !== want.px || got.py !== want.py || got.hd !== want.hd ||
              got.qz !== want.qz || got.qw !== want.qw || got.lin !== want.lin ||
              got.ang !== want.ang) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch #%0d expected: %p", poses_checked, want);
              $display("            actual:   %p", got);
            end
          end
        end
        nw = no_idle ? 0 : $urandom_range(7);
        out_ready <= (nw == 0);
        recv_wait <= nw;
      end else if (recv_wait > 0) begin
        out_ready <= (recv_wait == 1);
        recv_wait <= recv_wait - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [15:0] tpm_set[NUM_PHASES] = '{16'd1, 16'd65535, 16'd0, 16'd4900, 16'd200,
                                         16'd1, 16'd3000};
    logic [23:0] trk_set[NUM_PHASES] = '{24'd1, 24'hFFFFFF, 24'd0, 24'd47186, 24'd3000,
                                         24'hFFFFFF, 24'd40000};
    m_tpm = TPM_RESET;
    m_track = TRACK_RESET;
    m_x = '0; m_y = '0; m_hd = '0;
    for (int i = 0; i < 4; i++) begin
      m_prev[i] = '0;
      gen_prev[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: defaults from reset
    queue_exact(32'd0, 32'd0, 32'd0, 32'd0, 24'd1000);
    queue_exact(32'd4900, 32'd4900, 32'd4900, 32'd4900, 24'd1000);
    queue_exact(32'd9800, 32'd0, 32'd9800, 32'd0, 24'd20000);
    queue_exact(32'd9800, 32'd9800, 32'd9800, 32'd9800, 24'd0);
    queue_exact(32'd9800, 32'd9800, 32'd9800, 32'd9800, 24'd1);
    queue_exact(32'd100, 32'd19500, 32'd100, 32'd19500, 24'hFFFFFF);
    queue_exact(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'd1);
    queue_exact(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 24'd1);
    queue_exact(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 24'd1);
    queue_exact(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 24'd1);
    queue_exact(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF);
    queue_exact(32'd0, 32'hFFFFFFFF, 32'd1, 32'd0, 24'd7);
    for (int k = 0; k < 8; k++) queue_sample(3000, pick_dt(), 1'b0);
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(REG_TICKS, {8'd0, tpm_set[ph]});
      write_reg(REG_TRACK, trk_set[ph]);
      if (ph == 4) begin
        write_reg(REG_SPARE, 24'h00ABCD);
        write_reg(REG_UNUSED, 24'h123456);
      end
      if (ph == 6) begin
        write_reg(REG_TICKS, {8'd0, 16'($urandom_range(65535, 1))});
        write_reg(REG_TRACK, 24'($urandom_range(24'hFFFFFF, 1)));
      end
      no_idle = (ph == 3);
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        queue_sample(($urandom_range(9) == 0) ? 2000000000 : 4000, pick_dt(),
                     $urandom_range(19) == 0);
      wait_idle();
    end

    $display("Sent %0d items over %0d register settings, checked %0d poses",
             items_sent, NUM_PHASES + 1, poses_checked);
    $display("Covered wrap-around counts, saturating speeds, zero and extreme time steps");
    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d poses outstanding", mismatches, expected_poses.size());
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hdl
hdl/ddo_pkg.sv
hdl/ddo_div.sv
hdl/ddo_cordic.sv
hdl/ddo_datapath.sv
hdl/ddo_ctrl.sv
hdl/diff_drive_odometry_top.sv
hdl/ddo_checker.sv
bench/diff_drive_odometry_top_tb.sv
